### hw/rtl/ita_pkg.sv
// shared types, constants and character encoding for the ascii formatter
`timescale 1ns / 1ps

package ita_pkg;

	// format commands
	localparam logic [1:0] CmdSignedDec   = 2'd0;
	localparam logic [1:0] CmdUnsignedDec = 2'd1;
	localparam logic [1:0] CmdLowerHex    = 2'd2;
	localparam logic [1:0] CmdUpperHex    = 2'd3;

	// sizes
	localparam int ValueWidth = 32;
	localparam int DigitWidth = 4;
	localparam int CharWidth  = 8;
	localparam int StackDepth = 10;
	localparam int CountWidth = $clog2(StackDepth + 1);

	// ascii codes
	localparam logic [CharWidth-1:0] CharZero  = 8'h30;
	localparam logic [CharWidth-1:0] CharMinus = 8'h2D;
	localparam logic [CharWidth-1:0] CharLowA  = 8'h61;
	localparam logic [CharWidth-1:0] CharUpA   = 8'h41;

	// reciprocal of ten, scaled by 2^35
	localparam logic [ValueWidth-1:0] RecipTen = 32'hCCCC_CCCD;
	localparam int RecipShift = 35;

	// digit stack controls
	typedef struct packed {
		logic push;
		logic pop;
	} stk_ctl_t;

	// one digit value to its ascii character
	function automatic logic [CharWidth-1:0] digit_char(
		input logic [DigitWidth-1:0] d,
		input logic upper
	);
		logic [CharWidth-1:0] base;
		begin
			base = upper ? CharUpA : CharLowA;
			if (d < 4'd10) begin
				digit_char = CharZero + {4'b0, d};
			end else begin
				digit_char = base + {4'b0, d} - 8'd10;
			end
		end
	endfunction

endpackage

### hw/rtl/ita_digit_unit.sv
// shared digit unit: splits the low digit off a magnitude in radix 10 or 16
`timescale 1ns / 1ps

module ita_digit_unit (
	input  logic [ita_pkg::ValueWidth-1:0] mag,
	input  logic                           hex,
	output logic [ita_pkg::ValueWidth-1:0] quo,
	output logic [ita_pkg::DigitWidth-1:0] digit
);
	import ita_pkg::*;

	logic [2*ValueWidth-1:0] prod;
	logic [ValueWidth-1:0]   dec_quo;
	logic [ValueWidth-1:0]   dec_times_ten;
	logic [ValueWidth-1:0]   dec_rem;

	// divide by ten through the scaled reciprocal, exact for every 32-bit value
	assign prod          = {{ValueWidth{1'b0}}, mag} * {{ValueWidth{1'b0}}, RecipTen};
	assign dec_quo       = {{RecipShift-ValueWidth{1'b0}}, prod[2*ValueWidth-1:RecipShift]};
	assign dec_times_ten = {dec_quo[ValueWidth-4:0], 3'b000} + {dec_quo[ValueWidth-2:0], 1'b0};
	assign dec_rem       = mag - dec_times_ten;

	// radix select
	always_comb begin
		if (hex) begin
			quo   = {4'b0000, mag[ValueWidth-1:DigitWidth]};
			digit = mag[DigitWidth-1:0];
		end else begin
			quo   = dec_quo;
			digit = dec_rem[DigitWidth-1:0];
		end
	end

endmodule

### hw/rtl/ita_digit_stack.sv
// last-in first-out digit store built as a shift line
`timescale 1ns / 1ps

module ita_digit_stack (
	input  logic                           clk,
	input  ita_pkg::stk_ctl_t              ctl,
	input  logic [ita_pkg::DigitWidth-1:0] push_digit,
	output logic [ita_pkg::DigitWidth-1:0] top_digit
);
	import ita_pkg::*;

	logic [DigitWidth-1:0] stack_q [StackDepth];

	// push shifts toward the deep end, pop shifts back toward the top
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			stack_q[0] <= push_digit;
			for (int i = 1; i < StackDepth; i++) begin
				stack_q[i] <= stack_q[i-1];
			end
		end else if (ctl.pop) begin
			for (int i = 0; i < StackDepth - 1; i++) begin
				stack_q[i] <= stack_q[i+1];
			end
		end
	end

	assign top_digit = stack_q[0];

endmodule

### hw/rtl/integer_to_ascii_formatter_unit.sv
// top level: sequencer, output register and the digit unit and stack
`timescale 1ns / 1ps

// Integer to ASCII formatter.
// Input channel (in_valid/in_ready) takes one word: cmd selects signed decimal,
// unsigned decimal, lowercase hex or uppercase hex, and value is the 32-bit pattern.
// Output channel (out_valid/out_ready) gives one ASCII character per word, most
// significant first, with no leading zeros; last marks the final character.
// A negative signed value starts with '-', and zero gives a single '0'.
// Sequence: the word is taken, then the shared divide-by-ten / shift unit splits off
// the digits one by one (up to 10 decimal or 8 hex digits), then each character
// leaves the output register when the receiver is ready.
// The next word is taken only after the final character is loaded into the output
// register, so no new number is taken while one is still being formatted.
// in_ready is high only while the sequencer is idle; it may rise while the final
// character still waits in the output register.
// When out_ready is low the current character is held and the sequencer waits.
// Reset clears the sequencer and the output valid; no item is in flight after it.
module integer_to_ascii_formatter_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     cmd,
	input  logic [ita_pkg::ValueWidth-1:0] value,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [ita_pkg::CharWidth-1:0]  char_code,
	output logic                           last
);
	import ita_pkg::*;

	localparam logic [1:0] StIdle = 2'd0;
	localparam logic [1:0] StConv = 2'd1;
	localparam logic [1:0] StEmit = 2'd2;

	logic [1:0]            state_q;
	logic [ValueWidth-1:0] mag_q;
	logic                  neg_q;
	logic                  hex_q;
	logic                  upper_q;
	logic [CountWidth-1:0] cnt_q;
	logic                  out_valid_q;
	logic [CharWidth-1:0]  char_q;
	logic                  last_q;

	logic [ValueWidth-1:0] quo;
	logic [DigitWidth-1:0] digit;
	logic [DigitWidth-1:0] top_digit;
	stk_ctl_t              stk_ctl;
	logic                  accept;
	logic                  out_free;

	// shared digit unit
	ita_digit_unit u_digit (
		.mag   (mag_q),
		.hex   (hex_q),
		.quo   (quo),
		.digit (digit)
	);

	// digit store
	ita_digit_stack u_stack (
		.clk        (clk),
		.ctl        (stk_ctl),
		.push_digit (digit),
		.top_digit  (top_digit)
	);

	assign in_ready  = (state_q == StIdle);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign char_code = char_q;
	assign last      = last_q;

	// stack controls
	always_comb begin
		stk_ctl.push = (state_q == StConv);
		stk_ctl.pop  = (state_q == StEmit) && out_free && !neg_q;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			neg_q   <= 1'b0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				StIdle: begin
					if (accept) begin
						neg_q   <= (cmd == CmdSignedDec) && value[ValueWidth-1];
						cnt_q   <= '0;
						state_q <= StConv;
					end
				end
				StConv: begin
					cnt_q <= cnt_q + 1'b1;
					if (quo == '0) begin
						state_q <= StEmit;
					end
				end
				StEmit: begin
					if (out_free) begin
						if (neg_q) begin
							neg_q <= 1'b0;
						end else begin
							cnt_q <= cnt_q - 1'b1;
							if (cnt_q == CountWidth'(1)) begin
								state_q <= StIdle;
							end
						end
					end
				end
				default: begin
					state_q <= StIdle;
				end
			endcase
		end
	end

	// working magnitude and format flags
	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q   <= ((cmd == CmdSignedDec) && value[ValueWidth-1]) ? (~value + 1'b1) : value;
			hex_q   <= (cmd == CmdLowerHex) || (cmd == CmdUpperHex);
			upper_q <= (cmd == CmdUpperHex);
		end else if (state_q == StConv) begin
			mag_q <= quo;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == StEmit && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (state_q == StEmit && out_free) begin
			if (neg_q) begin
				char_q <= CharMinus;
				last_q <= 1'b0;
			end else begin
				char_q <= digit_char(top_digit, upper_q);
				last_q <= (cnt_q == CountWidth'(1));
			end
		end
	end

endmodule
